FILE: src/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define V3A_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: check failed");

// same, with a message of its own
`define V3A_ASSERT_MSG(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`endif

FILE: src/v3a_pkg.sv
package v3a_pkg;

	// default geometry of one coordinate
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// operation codes
	typedef enum logic [3:0] {
		KIND_ADD        = 4'd0,
		KIND_SUB        = 4'd1,
		KIND_CROSS      = 4'd2,
		KIND_DOT        = 4'd3,
		KIND_DIV        = 4'd4,
		KIND_MUL        = 4'd5,
		KIND_NEG        = 4'd6,
		KIND_EQUAL      = 4'd7,
		KIND_MAG        = 4'd8,
		KIND_NORMALIZE  = 4'd9,
		KIND_TRI_NORMAL = 4'd10
	} kind_t;

	// status codes
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_ERR = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	// pipeline control handed to the arithmetic units
	typedef struct packed {
		logic en;
		logic valid;
	} pipe_ctl_t;

endpackage

FILE: src/v3a_ifs.sv
// command channel
interface v3a_cmd_if #(parameter int W = v3a_pkg::COORD_WIDTH_DEF);
	logic                valid;
	logic                ready;
	logic [3:0]          kind;
	logic signed [W-1:0] a_x;
	logic signed [W-1:0] a_y;
	logic signed [W-1:0] a_z;
	logic signed [W-1:0] b_x;
	logic signed [W-1:0] b_y;
	logic signed [W-1:0] b_z;
	logic signed [W-1:0] c_x;
	logic signed [W-1:0] c_y;
	logic signed [W-1:0] c_z;
	logic signed [W-1:0] scalar_in;

	modport source (output valid, kind, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		scalar_in, input ready);
	modport sink (input valid, kind, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		scalar_in, output ready);
endinterface

// result channel
interface v3a_rsp_if #(parameter int W = v3a_pkg::COORD_WIDTH_DEF);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] res_x;
	logic signed [W-1:0] res_y;
	logic signed [W-1:0] res_z;
	logic signed [W-1:0] res_scalar;
	logic                is_equal;
	logic [1:0]          status;

	modport source (output valid, res_x, res_y, res_z, res_scalar, is_equal, status,
		input ready);
	modport sink (input valid, res_x, res_y, res_z, res_scalar, is_equal, status,
		output ready);
endinterface

FILE: src/vector3_alu_top.sv
// Three-component fixed-point vector ALU.
// cmd carries one operation per transaction: kind, vectors a, b, c and a scalar,
// all signed fixed point with FRAC_BITS fraction bits. rsp returns one result per
// transaction: vector, scalar, equality flag and status (ok, error, saturated).
// The datapath is a single pipeline of 2*COORD_WIDTH + FRAC_BITS + 7 register
// stages (87 at the default widths): five stages of add, multiply and square,
// one stage per root bit of the square root unit, one set-up stage, one stage per
// quotient bit of the three-lane divider, then the output register. Throughput is
// one transaction per cycle while the pipeline is not frozen; every operation
// takes the same path.
// cmd.ready is high whenever the output register is empty or being read. If the
// receiver holds rsp.ready low while a result waits, the whole pipeline freezes
// in place and cmd.ready drops; nothing is dropped or repeated.
// Reset clears every valid bit: rsp.valid goes low and cmd.ready comes up at once.
module vector3_alu_top #(
	parameter int COORD_WIDTH = v3a_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = v3a_pkg::FRAC_BITS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	v3a_cmd_if.sink   cmd,
	v3a_rsp_if.source rsp
);
	import v3a_pkg::*;
	`include "assert_macros.svh"

	localparam int W  = COORD_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int PW = 2 * W;
	localparam int XW = PW + 2;
	localparam int QW = W + F;

	localparam logic signed [XW-1:0] MAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [XW-1:0] MIN_X = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
	localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		kind_t                kind;
		logic [W-1:0]         s;
		logic [2:0][W-1:0]    nv;
		logic [2:0][W-1:0]    vec;
		logic [W-1:0]         sc;
		logic                 eq;
		logic                 sf;
	} root_side_t;

	typedef struct packed {
		kind_t                kind;
		logic [2:0][W-1:0]    vec;
		logic [W-1:0]         sc;
		logic [2:0]           neg;
		logic                 eq;
		logic                 sf;
		logic                 err;
	} div_side_t;

	function automatic logic ovf(input logic signed [XW-1:0] x);
		return (x > MAX_X) || (x < MIN_X);
	endfunction

	function automatic logic [W-1:0] clamp(input logic signed [XW-1:0] x);
		logic [W-1:0] r;
		if (x > MAX_X) r = SAT_MAX;
		else if (x < MIN_X) r = SAT_MIN;
		else r = x[W-1:0];
		return r;
	endfunction

	logic en;
	pipe_ctl_t sq_ctl, dv_ctl;

	// stage valid bits
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, out_valid_q;

	// ---------------- stage 1: linear ops and triangle edges
	kind_t                kind_in;
	logic [2:0][W-1:0]    a_in, b_in, c_in, lin_in, u_in, v_in;
	logic signed [XW-1:0] lin_raw [3];
	logic signed [XW-1:0] t1_raw  [3];
	logic signed [XW-1:0] t2_raw  [3];
	logic                 lin_ovf, tri_ovf, sf_in, eq_in;

	kind_t                kind_s1;
	logic [2:0][W-1:0]    u_s1, v_s1, a_s1, lin_s1;
	logic [W-1:0]         s_s1;
	logic                 eq_s1, sf_s1;

	assign kind_in = kind_t'(cmd.kind);
	assign a_in = {cmd.a_z, cmd.a_y, cmd.a_x};
	assign b_in = {cmd.b_z, cmd.b_y, cmd.b_x};
	assign c_in = {cmd.c_z, cmd.c_y, cmd.c_x};

	always_comb begin
		lin_ovf = 1'b0;
		tri_ovf = 1'b0;
		for (int i = 0; i < 3; i++) begin
			if (kind_in == KIND_SUB)
				lin_raw[i] = XW'($signed(a_in[i])) - XW'($signed(b_in[i]));
			else if (kind_in == KIND_NEG)
				lin_raw[i] = -XW'($signed(a_in[i]));
			else
				lin_raw[i] = XW'($signed(a_in[i])) + XW'($signed(b_in[i]));
			t1_raw[i] = XW'($signed(b_in[i])) - XW'($signed(a_in[i]));
			t2_raw[i] = XW'($signed(c_in[i])) - XW'($signed(a_in[i]));
			lin_in[i] = clamp(lin_raw[i]);
			lin_ovf   = lin_ovf | ovf(lin_raw[i]);
			tri_ovf   = tri_ovf | ovf(t1_raw[i]) | ovf(t2_raw[i]);
			if (kind_in == KIND_TRI_NORMAL) begin
				u_in[i] = clamp(t1_raw[i]);
				v_in[i] = clamp(t2_raw[i]);
			end else begin
				u_in[i] = a_in[i];
				v_in[i] = (kind_in == KIND_MUL) ? cmd.scalar_in : b_in[i];
			end
		end
		sf_in = ((kind_in == KIND_ADD || kind_in == KIND_SUB || kind_in == KIND_NEG) && lin_ovf)
			|| (kind_in == KIND_TRI_NORMAL && tri_ovf);
		eq_in = (kind_in == KIND_EQUAL) && (a_in == b_in);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= kind_in;
			u_s1    <= u_in;
			v_s1    <= v_in;
			a_s1    <= a_in;
			s_s1    <= cmd.scalar_in;
			lin_s1  <= lin_in;
			eq_s1   <= eq_in;
			sf_s1   <= sf_in;
		end
	end

	// ---------------- stage 2: six shared multipliers
	logic [5:0][W-1:0]    mx_a, mx_b;
	logic                 use_cross;
	logic [5:0][PW-1:0]   m_s2;
	kind_t                kind_s2;
	logic [2:0][W-1:0]    a_s2, lin_s2;
	logic [W-1:0]         s_s2;
	logic                 eq_s2, sf_s2;

	assign use_cross = (kind_s1 == KIND_CROSS) || (kind_s1 == KIND_TRI_NORMAL);

	// cross uses u_j*v_k in the first three and u_k*v_j in the last three
	always_comb begin
		mx_a[0] = use_cross ? u_s1[1] : u_s1[0];
		mx_b[0] = use_cross ? v_s1[2] : v_s1[0];
		mx_a[1] = use_cross ? u_s1[2] : u_s1[1];
		mx_b[1] = use_cross ? v_s1[0] : v_s1[1];
		mx_a[2] = use_cross ? u_s1[0] : u_s1[2];
		mx_b[2] = use_cross ? v_s1[1] : v_s1[2];
		mx_a[3] = u_s1[2];
		mx_b[3] = v_s1[1];
		mx_a[4] = u_s1[0];
		mx_b[4] = v_s1[2];
		mx_a[5] = u_s1[1];
		mx_b[5] = v_s1[0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < 6; n++)
				m_s2[n] <= PW'($signed(mx_a[n])) * PW'($signed(mx_b[n]));
			kind_s2 <= kind_s1;
			a_s2    <= a_s1;
			s_s2    <= s_s1;
			lin_s2  <= lin_s1;
			eq_s2   <= eq_s1;
			sf_s2   <= sf_s1;
		end
	end

	// ---------------- stage 3: combine products, scale and clamp
	logic signed [XW-1:0] cross_raw [3];
	logic signed [XW-1:0] mul_raw   [3];
	logic signed [XW-1:0] dot_raw;
	logic [2:0][W-1:0]    vec_c;
	logic [W-1:0]         sc_c;
	logic                 sf_c;

	logic [2:0][W-1:0]    vec_s3, a_s3;
	logic [W-1:0]         sc_s3, s_s3;
	kind_t                kind_s3;
	logic                 eq_s3, sf_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cross_raw[i] = (XW'($signed(m_s2[i])) - XW'($signed(m_s2[i+3]))) >>> F;
			mul_raw[i]   = XW'($signed(m_s2[i])) >>> F;
		end
		dot_raw = (XW'($signed(m_s2[0])) + XW'($signed(m_s2[1])) + XW'($signed(m_s2[2])))
			>>> F;
		vec_c = '0;
		sc_c  = '0;
		sf_c  = sf_s2;
		unique case (kind_s2) inside
			KIND_ADD, KIND_SUB, KIND_NEG: begin
				vec_c = lin_s2;
			end
			KIND_CROSS, KIND_TRI_NORMAL: begin
				for (int i = 0; i < 3; i++) begin
					vec_c[i] = clamp(cross_raw[i]);
					sf_c     = sf_c | ovf(cross_raw[i]);
				end
			end
			KIND_MUL: begin
				for (int i = 0; i < 3; i++) begin
					vec_c[i] = clamp(mul_raw[i]);
					sf_c     = sf_c | ovf(mul_raw[i]);
				end
			end
			KIND_DOT: begin
				sc_c = clamp(dot_raw);
				sf_c = sf_c | ovf(dot_raw);
			end
			default: begin
				vec_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s3  <= vec_c;
			sc_s3   <= sc_c;
			a_s3    <= a_s2;
			s_s3    <= s_s2;
			kind_s3 <= kind_s2;
			eq_s3   <= eq_s2;
			sf_s3   <= sf_s2 ? 1'b1 : sf_c;
		end
	end

	// ---------------- stage 4: squares of the vector to measure
	logic [2:0][W-1:0]    nv_c;
	logic [2:0][PW-1:0]   sq_s4;
	logic [2:0][W-1:0]    nv_s4, vec_s4;
	logic [W-1:0]         s_s4, sc_s4;
	kind_t                kind_s4;
	logic                 eq_s4, sf_s4;

	assign nv_c = (kind_s3 == KIND_TRI_NORMAL) ? vec_s3 : a_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				sq_s4[i] <= PW'($signed(nv_c[i])) * PW'($signed(nv_c[i]));
			nv_s4   <= nv_c;
			vec_s4  <= vec_s3;
			s_s4    <= s_s3;
			sc_s4   <= sc_s3;
			kind_s4 <= kind_s3;
			eq_s4   <= eq_s3;
			sf_s4   <= sf_s3;
		end
	end

	// ---------------- stage 5: sum of squares
	logic [PW-1:0] sum_s5;
	root_side_t    side_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s5       <= sq_s4[0] + sq_s4[1] + sq_s4[2];
			side_s5.kind <= kind_s4;
			side_s5.s    <= s_s4;
			side_s5.nv   <= nv_s4;
			side_s5.vec  <= vec_s4;
			side_s5.sc   <= sc_s4;
			side_s5.eq   <= eq_s4;
			side_s5.sf   <= sf_s4;
		end
	end

	// ---------------- square root
	logic                     sq_valid;
	logic [W-1:0]             root;
	logic [$bits(root_side_t)-1:0] sq_tag;
	root_side_t               rs;

	assign sq_ctl = '{en: en, valid: valid_s5};

	v3a_sqrt #(
		.IN_W  (PW),
		.OUT_W (W),
		.TAG_W ($bits(root_side_t))
	) u_sqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (sq_ctl),
		.radicand   (sum_s5),
		.tag        (side_s5),
		.done_valid (sq_valid),
		.root       (root),
		.done_tag   (sq_tag)
	);

	assign rs = root_side_t'(sq_tag);

	// ---------------- stage 6: divider operands, error and magnitude
	logic [W-1:0]          abs_s;
	logic [2:0][W-1:0]     abs_nv;
	logic [2:0][QW-1:0]    num_c;
	logic                  is_div, is_norm;
	div_side_t             side_c;

	logic [W-1:0]          den_s6;
	logic [2:0][QW-1:0]    num_s6;
	div_side_t             side_s6;

	assign is_div  = (rs.kind == KIND_DIV);
	assign is_norm = (rs.kind == KIND_NORMALIZE) || (rs.kind == KIND_TRI_NORMAL);
	assign abs_s   = rs.s[W-1] ? (~rs.s + 1'b1) : rs.s;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			abs_nv[i]     = rs.nv[i][W-1] ? (~rs.nv[i] + 1'b1) : rs.nv[i];
			num_c[i]      = {abs_nv[i], {F{1'b0}}};
			side_c.neg[i] = rs.nv[i][W-1] ^ (is_div & rs.s[W-1]);
		end
		side_c.kind = rs.kind;
		side_c.vec  = rs.vec;
		side_c.eq   = rs.eq;
		side_c.err  = (is_div && rs.s == '0) || (is_norm && root == '0);
		if (rs.kind == KIND_MAG) begin
			side_c.sc = root[W-1] ? SAT_MAX : root;
			side_c.sf = rs.sf | root[W-1];
		end else begin
			side_c.sc = rs.sc;
			side_c.sf = rs.sf;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s6  <= is_div ? abs_s : root;
			num_s6  <= num_c;
			side_s6 <= side_c;
		end
	end

	// ---------------- divider
	logic                        dv_valid;
	logic [2:0][QW-1:0]          quot;
	logic [$bits(div_side_t)-1:0] dv_tag;
	div_side_t                   ds;

	assign dv_ctl = '{en: en, valid: valid_s6};

	v3a_div #(
		.NUM_W (QW),
		.DEN_W (W),
		.TAG_W ($bits(div_side_t))
	) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (dv_ctl),
		.num        (num_s6),
		.den        (den_s6),
		.tag        (side_s6),
		.done_valid (dv_valid),
		.quot       (quot),
		.done_tag   (dv_tag)
	);

	assign ds = div_side_t'(dv_tag);

	// ---------------- final: sign, clamp, error override
	logic signed [XW-1:0] q_signed [3];
	logic [2:0][W-1:0]    res_c;
	logic [W-1:0]         sc_f;
	logic                 sf_f, eq_f;
	logic [1:0]           st_f;

	always_comb begin
		sf_f  = ds.sf;
		res_c = ds.vec;
		for (int i = 0; i < 3; i++)
			q_signed[i] = ds.neg[i] ? -$signed(XW'(quot[i])) : $signed(XW'(quot[i]));
		unique case (ds.kind) inside
			KIND_DIV, KIND_NORMALIZE, KIND_TRI_NORMAL: begin
				for (int i = 0; i < 3; i++) begin
					res_c[i] = clamp(q_signed[i]);
					sf_f     = sf_f | ovf(q_signed[i]);
				end
			end
			default: begin
				res_c = ds.vec;
			end
		endcase
		sc_f = ds.sc;
		eq_f = ds.eq;
		if (ds.err) begin
			res_c = '0;
			sc_f  = '0;
			st_f  = ST_ERR;
		end else if (sf_f) begin
			st_f = ST_SAT;
		end else begin
			st_f = ST_OK;
		end
	end

	// ---------------- output register
	logic [2:0][W-1:0] res_q;
	logic [W-1:0]      sc_q;
	logic              eq_q;
	logic [1:0]        st_q;

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_c;
			sc_q  <= sc_f;
			eq_q  <= eq_f;
			st_q  <= st_f;
		end
	end

	// pipeline advances unless a result waits on a stalled receiver
	assign en = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			valid_s6    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= cmd.valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			valid_s5    <= valid_s4;
			valid_s6    <= sq_valid;
			out_valid_q <= dv_valid;
		end
	end

	assign cmd.ready      = en;
	assign rsp.valid      = out_valid_q;
	assign rsp.res_x      = res_q[0];
	assign rsp.res_y      = res_q[1];
	assign rsp.res_z      = res_q[2];
	assign rsp.res_scalar = sc_q;
	assign rsp.is_equal   = eq_q;
	assign rsp.status     = st_q;

	// ---------------- checks
	`V3A_ASSERT(a_err_zeroes, rsp.valid && rsp.status == ST_ERR |-> rsp.res_x == '0 && rsp.res_y == '0 && rsp.res_z == '0 && rsp.res_scalar == '0)
	`V3A_ASSERT(a_equal_clean, rsp.valid && rsp.is_equal |-> rsp.status == ST_OK && rsp.res_scalar == '0)
	`V3A_ASSERT_MSG(a_status_code, rsp.valid |-> rsp.status == ST_OK || rsp.status == ST_ERR || rsp.status == ST_SAT, "illegal status code")
	`V3A_ASSERT_MSG(a_stall_cause, !cmd.ready |-> rsp.valid && !rsp.ready, "stall without a waiting result")

endmodule

FILE: src/v3a_sqrt.sv
// pipelined integer square root, one result bit per stage
module v3a_sqrt #(
	parameter int IN_W  = 64,
	parameter int OUT_W = 32,
	parameter int TAG_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  v3a_pkg::pipe_ctl_t   ctl,
	input  logic [IN_W-1:0]      radicand,
	input  logic [TAG_W-1:0]     tag,
	output logic                 done_valid,
	output logic [OUT_W-1:0]     root,
	output logic [TAG_W-1:0]     done_tag
);

	logic                val_s  [OUT_W];
	logic [IN_W-1:0]     rem_s  [OUT_W];
	logic [OUT_W-1:0]    root_s [OUT_W];
	logic [TAG_W-1:0]    tag_s  [OUT_W];

	logic [IN_W-1:0]     nxt_rem  [OUT_W];
	logic [OUT_W-1:0]    nxt_root [OUT_W];

	// remainder holds radicand minus root squared; try the next root bit
	always_comb begin
		logic [IN_W-1:0]  src_rem;
		logic [OUT_W-1:0] src_root;
		logic [IN_W-1:0]  trial;
		int               bitpos;
		for (int k = 0; k < OUT_W; k++) begin
			bitpos = OUT_W - 1 - k;
			if (k == 0) begin
				src_rem  = radicand;
				src_root = '0;
			end else begin
				src_rem  = rem_s[k-1];
				src_root = root_s[k-1];
			end
			trial = (IN_W'(src_root) << (bitpos + 1)) | (IN_W'(1) << (2 * bitpos));
			nxt_rem[k]  = src_rem;
			nxt_root[k] = src_root;
			if (src_rem >= trial) begin
				nxt_rem[k]          = src_rem - trial;
				nxt_root[k][bitpos] = 1'b1;
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < OUT_W; k++) val_s[k] <= 1'b0;
		end else if (ctl.en) begin
			for (int k = 0; k < OUT_W; k++) val_s[k] <= (k == 0) ? ctl.valid : val_s[k-1];
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int k = 0; k < OUT_W; k++) begin
				rem_s[k]  <= nxt_rem[k];
				root_s[k] <= nxt_root[k];
				tag_s[k]  <= (k == 0) ? tag : tag_s[k-1];
			end
		end
	end

	assign done_valid = val_s[OUT_W-1];
	assign root       = root_s[OUT_W-1];
	assign done_tag   = tag_s[OUT_W-1];

endmodule

FILE: src/v3a_div.sv
// pipelined restoring divider, three lanes over one divisor, one quotient bit per stage
module v3a_div #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 32,
	parameter int TAG_W = 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  v3a_pkg::pipe_ctl_t        ctl,
	input  logic [2:0][NUM_W-1:0]     num,
	input  logic [DEN_W-1:0]          den,
	input  logic [TAG_W-1:0]          tag,
	output logic                      done_valid,
	output logic [2:0][NUM_W-1:0]     quot,
	output logic [TAG_W-1:0]          done_tag
);

	logic                    val_s [NUM_W];
	logic [2:0][NUM_W-1:0]   num_s [NUM_W];
	logic [2:0][NUM_W-1:0]   q_s   [NUM_W];
	logic [2:0][DEN_W-1:0]   rem_s [NUM_W];
	logic [DEN_W-1:0]        den_s [NUM_W];
	logic [TAG_W-1:0]        tag_s [NUM_W];

	logic [2:0][NUM_W-1:0]   nxt_q   [NUM_W];
	logic [2:0][DEN_W-1:0]   nxt_rem [NUM_W];

	// bring down one dividend bit, subtract when it fits
	always_comb begin
		logic [2:0][NUM_W-1:0] src_num;
		logic [2:0][NUM_W-1:0] src_q;
		logic [2:0][DEN_W-1:0] src_rem;
		logic [DEN_W-1:0]      src_den;
		logic [DEN_W:0]        trial;
		logic [DEN_W:0]        diff;
		int                    bitpos;
		for (int k = 0; k < NUM_W; k++) begin
			bitpos = NUM_W - 1 - k;
			if (k == 0) begin
				src_num = num;
				src_q   = '0;
				src_rem = '0;
				src_den = den;
			end else begin
				src_num = num_s[k-1];
				src_q   = q_s[k-1];
				src_rem = rem_s[k-1];
				src_den = den_s[k-1];
			end
			for (int l = 0; l < 3; l++) begin
				trial = {src_rem[l], src_num[l][bitpos]};
				diff  = trial - {1'b0, src_den};
				nxt_q[k][l] = src_q[l];
				if (trial >= {1'b0, src_den}) begin
					nxt_rem[k][l]       = diff[DEN_W-1:0];
					nxt_q[k][l][bitpos] = 1'b1;
				end else begin
					nxt_rem[k][l] = trial[DEN_W-1:0];
				end
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_W; k++) val_s[k] <= 1'b0;
		end else if (ctl.en) begin
			for (int k = 0; k < NUM_W; k++) val_s[k] <= (k == 0) ? ctl.valid : val_s[k-1];
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int k = 0; k < NUM_W; k++) begin
				q_s[k]   <= nxt_q[k];
				rem_s[k] <= nxt_rem[k];
				num_s[k] <= (k == 0) ? num : num_s[k-1];
				den_s[k] <= (k == 0) ? den : den_s[k-1];
				tag_s[k] <= (k == 0) ? tag : tag_s[k-1];
			end
		end
	end

	assign done_valid = val_s[NUM_W-1];
	assign quot       = q_s[NUM_W-1];
	assign done_tag   = tag_s[NUM_W-1];

endmodule

FILE: verif/tb_vector3_alu_top.sv
`timescale 1ns / 100ps

module tb_vector3_alu_top;
	import v3a_pkg::*;

	typedef logic signed [31:0]  coord_t;
	typedef logic signed [127:0] acc_t;
	typedef coord_t vec_t [3];

	// opcodes the block leaves unused
	localparam logic [3:0] KIND_SPARE_LO = 4'd11;
	localparam logic [3:0] KIND_SPARE_HI = 4'd15;

	localparam coord_t MAXC = 32'sh7fffffff;
	localparam coord_t MINC = 32'sh80000000;
	localparam coord_t ONE  = 32'sh00010000;

	typedef struct {
		logic [3:0] kind;
		vec_t       a;
		vec_t       b;
		vec_t       c;
		coord_t     s;
	} op_t;

	typedef struct {
		coord_t     x;
		coord_t     y;
		coord_t     z;
		coord_t     sc;
		logic       eq;
		logic [1:0] st;
	} res_t;

	logic clk;
	logic arst_n;

	v3a_cmd_if cmd_if();
	v3a_rsp_if rsp_if();

	vector3_alu_top uut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_if),
		.rsp   (rsp_if)
	);

	res_t pending_q[$];
	int   mismatches = 0;
	int   idle_pct   = 0;
	int   stall_pct  = 0;
	int   hold_left  = 0;

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// arithmetic helpers for the predictor
	function automatic acc_t widen(input coord_t v);
		return v;
	endfunction

	function automatic acc_t abs_w(input coord_t v);
		acc_t t;
		t = v;
		return (t < 0) ? -t : t;
	endfunction

	function automatic coord_t clamp(input acc_t x, inout bit ovf);
		if (x > 128'sd2147483647) begin
			ovf = 1'b1;
			return MAXC;
		end
		if (x < -128'sd2147483648) begin
			ovf = 1'b1;
			return MINC;
		end
		return x[31:0];
	endfunction

	function automatic logic [63:0] root_floor(input acc_t s);
		logic [63:0]  r;
		logic [127:0] t;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= $unsigned(s))
				r = t[63:0];
		end
		return r;
	endfunction

	function automatic acc_t sum_sq(input vec_t v);
		return widen(v[0]) * widen(v[0]) + widen(v[1]) * widen(v[1])
			+ widen(v[2]) * widen(v[2]);
	endfunction

	function automatic void cross_prod(input vec_t a, input vec_t b, output vec_t o,
		inout bit ovf);
		acc_t d;
		int   j;
		int   k;
		for (int i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			k = (i + 2) % 3;
			d = widen(a[j]) * widen(b[k]) - widen(a[k]) * widen(b[j]);
			o[i] = clamp(d >>> 16, ovf);
		end
	endfunction

	function automatic void unit_vec(input vec_t v, output vec_t o, inout bit err,
		inout bit ovf);
		logic [63:0]  m;
		logic [127:0] q;
		acc_t         val;
		o = '{0, 0, 0};
		m = root_floor(sum_sq(v));
		if (m == 0) begin
			err = 1'b1;
			return;
		end
		for (int i = 0; i < 3; i++) begin
			q   = $unsigned(abs_w(v[i]) << 16) / {64'd0, m};
			val = (v[i] < 0) ? -$signed(q) : $signed(q);
			o[i] = clamp(val, ovf);
		end
	endfunction

	// expected result of one operation
	function automatic res_t alu_result(input op_t c);
		res_t         r;
		vec_t         o;
		vec_t         t1;
		vec_t         t2;
		vec_t         t3;
		bit           err;
		bit           ovf;
		logic [127:0] q;
		acc_t         val;
		o   = '{0, 0, 0};
		r   = '{0, 0, 0, 0, 1'b0, ST_OK};
		err = 1'b0;
		ovf = 1'b0;
		case (c.kind)
			KIND_ADD:
				for (int i = 0; i < 3; i++) o[i] = clamp(widen(c.a[i]) + widen(c.b[i]), ovf);
			KIND_SUB:
				for (int i = 0; i < 3; i++) o[i] = clamp(widen(c.a[i]) - widen(c.b[i]), ovf);
			KIND_CROSS: cross_prod(c.a, c.b, o, ovf);
			KIND_DOT:
				r.sc = clamp((widen(c.a[0]) * widen(c.b[0]) + widen(c.a[1]) * widen(c.b[1])
					+ widen(c.a[2]) * widen(c.b[2])) >>> 16, ovf);
			KIND_DIV: begin
				if (c.s == 0)
					err = 1'b1;
				else
					for (int i = 0; i < 3; i++) begin
						q   = $unsigned(abs_w(c.a[i]) << 16) / $unsigned(abs_w(c.s));
						val = ((c.a[i] < 0) != (c.s < 0)) ? -$signed(q) : $signed(q);
						o[i] = clamp(val, ovf);
					end
			end
			KIND_MUL:
				for (int i = 0; i < 3; i++) o[i] = clamp((widen(c.a[i]) * widen(c.s)) >>> 16, ovf);
			KIND_NEG:
				for (int i = 0; i < 3; i++) o[i] = clamp(-widen(c.a[i]), ovf);
			KIND_EQUAL: r.eq = (c.a[0] == c.b[0]) && (c.a[1] == c.b[1]) && (c.a[2] == c.b[2]);
			KIND_MAG: r.sc = clamp($signed({64'd0, root_floor(sum_sq(c.a))}), ovf);
			KIND_NORMALIZE: unit_vec(c.a, o, err, ovf);
			KIND_TRI_NORMAL: begin
				for (int i = 0; i < 3; i++) begin
					t1[i] = clamp(widen(c.b[i]) - widen(c.a[i]), ovf);
					t2[i] = clamp(widen(c.c[i]) - widen(c.a[i]), ovf);
				end
				cross_prod(t1, t2, t3, ovf);
				unit_vec(t3, o, err, ovf);
			end
			default: ;
		endcase
		// an error clears every value and outranks saturation
		if (err) begin
			r.x  = 0;
			r.y  = 0;
			r.z  = 0;
			r.sc = 0;
			r.st = ST_ERR;
		end else begin
			r.x  = o[0];
			r.y  = o[1];
			r.z  = o[2];
			r.st = ovf ? ST_SAT : ST_OK;
		end
		return r;
	endfunction

	// send one transaction and record its expected result
	task automatic send_op(input op_t c);
		while ($urandom_range(99) < idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid     <= 1'b1;
		cmd_if.kind      <= c.kind;
		cmd_if.a_x       <= c.a[0];
		cmd_if.a_y       <= c.a[1];
		cmd_if.a_z       <= c.a[2];
		cmd_if.b_x       <= c.b[0];
		cmd_if.b_y       <= c.b[1];
		cmd_if.b_z       <= c.b[2];
		cmd_if.c_x       <= c.c[0];
		cmd_if.c_y       <= c.c[1];
		cmd_if.c_z       <= c.c[2];
		cmd_if.scalar_in <= c.s;
		do @(posedge clk); while (!cmd_if.ready);
		pending_q.push_back(alu_result(c));
	endtask

	task automatic drop_valid();
		cmd_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic op_t make_op(input logic [3:0] k, input vec_t a, input vec_t b,
		input vec_t c, input coord_t s);
		op_t r;
		r.kind = k;
		r.a    = a;
		r.b    = b;
		r.c    = c;
		r.s    = s;
		return r;
	endfunction

	// operand mix: full range, extremes, zero and small values
	function automatic coord_t rand_coord();
		case ($urandom_range(9))
			0, 1, 2: return $urandom;
			3: return MAXC;
			4: return MINC;
			5: return 0;
			default: return int'($urandom_range(2097152)) - 1048576;
		endcase
	endfunction

	function automatic op_t rand_op();
		op_t r;
		if ($urandom_range(19) == 0)
			r.kind = $urandom_range(KIND_SPARE_HI, KIND_SPARE_LO);
		else
			r.kind = $urandom_range(KIND_TRI_NORMAL);
		for (int i = 0; i < 3; i++) begin
			r.a[i] = rand_coord();
			r.b[i] = rand_coord();
			r.c[i] = rand_coord();
		end
		r.s = rand_coord();
		// equal vectors, or nearly equal, for the compare
		if (r.kind == KIND_EQUAL && $urandom_range(1))
			r.b = r.a;
		if (r.kind == KIND_EQUAL && $urandom_range(3) == 0)
			r.b[$urandom_range(2)] ^= coord_t'(1) << $urandom_range(31);
		// degenerate triangles now and then
		if (r.kind == KIND_TRI_NORMAL && $urandom_range(5) == 0)
			r.c = r.b;
		return r;
	endfunction

	task automatic report(input string what, input coord_t exp_v, input coord_t act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, what, exp_v, act_v);
			mismatches++;
		end
	endtask

	// compare one result transaction with the oldest expectation
	task automatic check_result();
		res_t e;
		if (pending_q.size() == 0) begin
			$display("%0t: unexpected result transaction: expected none, actual %h %h %h %h",
				$time, rsp_if.res_x, rsp_if.res_y, rsp_if.res_z, rsp_if.res_scalar);
			mismatches++;
			return;
		end
		e = pending_q.pop_front();
		report("res_x", e.x, rsp_if.res_x);
		report("res_y", e.y, rsp_if.res_y);
		report("res_z", e.z, rsp_if.res_z);
		report("res_scalar", e.sc, rsp_if.res_scalar);
		report("is_equal", coord_t'(e.eq), coord_t'(rsp_if.is_equal));
		report("status", coord_t'(e.st), coord_t'(rsp_if.status));
	endtask

	// result side: check and stall
	initial begin
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready)
				check_result();
			if (hold_left > 0)
				rsp_if.ready <= 1'b0;
			else
				rsp_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// long receiver hold-off, counted down in cycles
	initial forever begin
		@(posedge clk);
		if (hold_left > 0)
			hold_left--;
	end

	task automatic wait_drained();
		while (pending_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		vec_t zv;
		vec_t mx;
		vec_t mn;
		vec_t v1;
		vec_t v2;
		zv = '{0, 0, 0};
		mx = '{MAXC, MAXC, MAXC};
		mn = '{MINC, MINC, MINC};
		v1 = '{ONE, 2 * ONE, -3 * ONE};
		v2 = '{-ONE, 5 * ONE, ONE / 2};
		idle_pct  = 0;
		stall_pct = 0;
		send_op(make_op(KIND_ADD, v1, v2, zv, 0));
		send_op(make_op(KIND_ADD, mx, mx, zv, 0));
		send_op(make_op(KIND_ADD, mn, mn, zv, 0));
		send_op(make_op(KIND_SUB, mx, mn, zv, 0));
		send_op(make_op(KIND_SUB, v1, v2, zv, 0));
		send_op(make_op(KIND_CROSS, v1, v2, zv, 0));
		send_op(make_op(KIND_CROSS, '{MAXC, MINC, MAXC}, '{MINC, MAXC, MAXC}, zv, 0));
		send_op(make_op(KIND_DOT, v1, v2, zv, 0));
		send_op(make_op(KIND_DOT, mn, mn, zv, 0));
		send_op(make_op(KIND_DIV, v1, zv, zv, 0));
		send_op(make_op(KIND_DIV, mx, zv, zv, 0));
		send_op(make_op(KIND_DIV, v1, zv, zv, -2 * ONE));
		send_op(make_op(KIND_DIV, mn, zv, zv, 1));
		send_op(make_op(KIND_MUL, v1, zv, zv, MINC));
		send_op(make_op(KIND_MUL, mx, zv, zv, MAXC));
		send_op(make_op(KIND_NEG, mn, zv, zv, 0));
		send_op(make_op(KIND_NEG, v1, zv, zv, 0));
		send_op(make_op(KIND_EQUAL, v1, v1, zv, 0));
		send_op(make_op(KIND_EQUAL, v1, v2, zv, 0));
		send_op(make_op(KIND_MAG, mn, zv, zv, 0));
		send_op(make_op(KIND_MAG, zv, zv, zv, 0));
		send_op(make_op(KIND_NORMALIZE, zv, zv, zv, 0));
		send_op(make_op(KIND_NORMALIZE, '{0, 0, 1}, zv, zv, 0));
		send_op(make_op(KIND_TRI_NORMAL, zv, v1, v1, 0));
		send_op(make_op(KIND_TRI_NORMAL, mn, mx, '{MAXC, MINC, 0}, 0));
		send_op(make_op(KIND_SPARE_LO, v1, v2, v1, ONE));
		send_op(make_op(KIND_SPARE_HI, mx, mn, mx, MINC));
		drop_valid();
	endtask

	task automatic test_random(input int count, input int idle, input int stall);
		idle_pct  = idle;
		stall_pct = stall;
		for (int n = 0; n < count; n++)
			send_op(rand_op());
		drop_valid();
	endtask

	// receiver holds off long enough for the pipeline to fill and stall cmd
	task automatic test_backpressure();
		idle_pct  = 0;
		stall_pct = 0;
		hold_left = 400;
		for (int n = 0; n < 120; n++)
			send_op(rand_op());
		drop_valid();
	endtask

	// sender waits for every result before going on
	task automatic test_drain_pause();
		wait_drained();
		test_random(10, 0, 0);
	endtask

	initial begin
		arst_n           <= 1'b0;
		cmd_if.valid     <= 1'b0;
		cmd_if.kind      <= KIND_ADD;
		cmd_if.a_x       <= '0;
		cmd_if.a_y       <= '0;
		cmd_if.a_z       <= '0;
		cmd_if.b_x       <= '0;
		cmd_if.b_y       <= '0;
		cmd_if.b_z       <= '0;
		cmd_if.c_x       <= '0;
		cmd_if.c_y       <= '0;
		cmd_if.c_z       <= '0;
		cmd_if.scalar_in <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(100, 0, 0);
		test_random(70, 60, 0);
		test_random(70, 0, 60);
		test_random(70, 20, 20);
		test_backpressure();
		test_drain_pause();

		wait_drained();
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("tb_vector3_alu_top passed");
		else
			$display("tb_vector3_alu_top failed");
		$finish;
	end

	// overall time limit
	initial begin
		#5000000;
		$display("tb_vector3_alu_top failed");
		$finish;
	end

endmodule
